>>> rtl/mmcd_pkg.sv
// shared constants, tables, and types for the multi-mode clock divider
// no dependencies; used by the interfaces, the lane module and the top level
package mmcd_pkg;

  localparam int OUTPUTS   = 8;
  localparam int LANE_W    = 3;
  localparam int GATE_W    = 8;
  localparam int PHASE_W   = 8;
  localparam int DIV_W     = 9;
  localparam int PULSE_W   = 16;
  localparam int RAND_W    = 16;
  localparam int DMODE_W   = 3;
  localparam int OMODE_W   = 2;
  localparam int STEP_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  // division modes
  localparam logic [DMODE_W-1:0] DIV_INT    = 3'd0;
  localparam logic [DMODE_W-1:0] DIV_EVEN   = 3'd1;
  localparam logic [DMODE_W-1:0] DIV_ODD    = 3'd2;
  localparam logic [DMODE_W-1:0] DIV_PRIME  = 3'd3;
  localparam logic [DMODE_W-1:0] DIV_BINARY = 3'd4;
  localparam logic [DMODE_W-1:0] DIV_RANDOM = 3'd5;
  localparam logic [DMODE_W-1:0] DIV_SEQ    = 3'd6;

  // output modes
  localparam logic [OMODE_W-1:0] OUT_GATE = 2'd0;
  localparam logic [OMODE_W-1:0] OUT_TRIG = 2'd1;
  localparam logic [OMODE_W-1:0] OUT_LONG = 2'd2;
  localparam logic [OMODE_W-1:0] OUT_ASIS = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIVISION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE    = 2'd2;

  localparam logic [PULSE_W-1:0] PULSE_RESET = 16'd48;

  typedef logic [DIV_W-1:0] div_row_t [8];

  localparam div_row_t DIV_TAB_INT    = '{9'd2, 9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8, 9'd9};
  localparam div_row_t DIV_TAB_EVEN   = '{9'd2, 9'd4, 9'd6, 9'd8, 9'd10, 9'd12, 9'd14, 9'd16};
  localparam div_row_t DIV_TAB_ODD    = '{9'd3, 9'd5, 9'd7, 9'd9, 9'd11, 9'd13, 9'd15, 9'd17};
  localparam div_row_t DIV_TAB_PRIME  = '{9'd2, 9'd3, 9'd5, 9'd7, 9'd11, 9'd13, 9'd17, 9'd19};
  localparam div_row_t DIV_TAB_BINARY = '{9'd2, 9'd4, 9'd8, 9'd16, 9'd32, 9'd64, 9'd128,
                                          9'd256};

  // 65535 / integer divisor, for random thinning
  typedef logic [RAND_W-1:0] rand_row_t [8];
  localparam rand_row_t RAND_LIMIT = '{16'd32767, 16'd21845, 16'd16383, 16'd13107,
                                       16'd10922, 16'd9362, 16'd8191, 16'd7281};

  // divisor of one output; unused and random/sequence modes use the integer row
  function automatic logic [DIV_W-1:0] divisor_of(input logic [DMODE_W-1:0] mode,
                                                  input logic [LANE_W-1:0] idx);
    logic [DIV_W-1:0] d;
    case (mode)
      DIV_EVEN:   d = DIV_TAB_EVEN[idx];
      DIV_ODD:    d = DIV_TAB_ODD[idx];
      DIV_PRIME:  d = DIV_TAB_PRIME[idx];
      DIV_BINARY: d = DIV_TAB_BINARY[idx];
      default:    d = DIV_TAB_INT[idx];
    endcase
    return d;
  endfunction

  // rotate left by two bits per output index
  function automatic logic [RAND_W-1:0] rotl2(input logic [RAND_W-1:0] w,
                                              input logic [LANE_W-1:0] idx);
    logic [2*RAND_W-1:0] dbl;
    logic [2*RAND_W-1:0] sh;
    dbl = {w, w};
    sh  = dbl << {idx, 1'b0};
    return sh[2*RAND_W-1:RAND_W];
  endfunction

  // control shared by all lanes for the item being processed
  typedef struct packed {
    logic                 update;
    logic                 clock_edge;
    logic                 clock_level;
    logic                 restart;
    logic                 phase_advance;
    logic                 started;
    logic [DMODE_W-1:0]   division_mode;
    logic [OMODE_W-1:0]   output_mode;
    logic [PULSE_W-1:0]   pulse_length;
    logic [STEP_W-1:0]    step;
    logic [RAND_W-1:0]    random_word;
  } lane_ctrl_t;

endpackage

>>> rtl/mmcd_sample_if.sv
// sample tick channel: valid/ready handshake and the four tick fields
// depends on mmcd_pkg for field widths
interface mmcd_sample_if;
  import mmcd_pkg::*;

  logic                valid;
  logic                ready;
  logic                clock_edge;
  logic                clock_level;
  logic                reset_edge;
  logic [RAND_W-1:0]   random_word;

  modport source (output valid, clock_edge, clock_level, reset_edge, random_word,
                  input ready);
  modport sink   (input valid, clock_edge, clock_level, reset_edge, random_word,
                  output ready);
endinterface

>>> rtl/mmcd_result_if.sv
// result channel: valid/ready handshake and the gate vector
// depends on mmcd_pkg for the gate width
interface mmcd_result_if;
  import mmcd_pkg::*;

  logic              valid;
  logic              ready;
  logic [GATE_W-1:0] gates;

  modport source (output valid, gates, input ready);
  modport sink   (input valid, gates, output ready);
endinterface

>>> rtl/multi_mode_clock_divider.sv
// multi-mode clock divider top level: tick register, shared control, output lanes
// depends on mmcd_pkg, mmcd_sample_if, mmcd_result_if and mmcd_lane
//
// usage
//   sample: one transaction per sample tick (clock edge flag, clock level,
//     reset edge flag, random word); taken when valid and ready are high
//   result: one transaction per tick carrying the eight gate levels
//   cfg: write port, cfg_index selects division mode, output mode or pulse
//     length; write only while no tick is in flight; a division mode write,
//     even of the same value, restarts all phases and the sequence step
// timing
//   result valid is registered: the sample passes the tick register, then the
//   lane logic into the result register; throughput is one tick per cycle
//   while the result is not stalled; the lane update is a single pass of
//   narrow compares and a 16-bit decrement per output, all lanes in parallel
// reset
//   rst (synchronous, high) clears both handshake stages, all phases, pulse
//   counters, gates and the started flag; registers go to their reset values
// stall
//   a stalled result holds the result register; the tick register keeps
//   accepting until it is also full, so ready drops only with both stages full
module multi_mode_clock_divider (
  input  logic                           clk,
  input  logic                           rst,
  mmcd_sample_if.sink                    sample,
  mmcd_result_if.source                  result,
  input  logic                           cfg_we,
  input  logic [mmcd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mmcd_pkg::CFG_W-1:0]     cfg_data
);
  import mmcd_pkg::*;

  // configuration registers
  logic [DMODE_W-1:0] division_mode;
  logic [OMODE_W-1:0] output_mode;
  logic [PULSE_W-1:0] pulse_length;

  // tick register
  logic               tick_valid;
  logic               tick_clock_edge;
  logic               tick_clock_level;
  logic               tick_reset_edge;
  logic [RAND_W-1:0]  tick_random_word;

  // result register
  logic               res_valid;
  logic [GATE_W-1:0]  res_gates;

  // shared state
  logic               started;
  logic               started_next;
  logic [STEP_W-1:0]  step;
  logic [STEP_W-1:0]  step_next;

  logic               advance;
  logic               started_cur;
  logic               restart_cfg;
  lane_ctrl_t         ctrl;
  logic [OUTPUTS-1:0] lane_gates;

  // result register is free or draining this cycle
  assign advance      = tick_valid && (!res_valid || result.ready);
  assign sample.ready = !tick_valid || advance;
  assign result.valid = res_valid;
  assign result.gates = res_gates;

  assign restart_cfg = cfg_we && (cfg_index == REG_DIVISION);

  // a reset edge drops started before the clock edge is looked at
  always_comb begin
    started_cur  = started && !tick_reset_edge;
    started_next = started_cur || tick_clock_edge;
    step_next    = tick_reset_edge ? '0 : step;
    if (tick_clock_edge && started_cur) begin
      step_next = step_next + STEP_W'(1);
    end
  end

  always_comb begin
    ctrl.update        = advance;
    ctrl.clock_edge    = tick_clock_edge;
    ctrl.clock_level   = tick_clock_level;
    ctrl.restart       = restart_cfg || (advance && tick_reset_edge);
    ctrl.phase_advance = tick_clock_edge && started_cur;
    ctrl.started       = started_next;
    ctrl.division_mode = division_mode;
    ctrl.output_mode   = output_mode;
    ctrl.pulse_length  = pulse_length;
    ctrl.step          = step_next;
    ctrl.random_word   = tick_random_word;
  end

  // one lane per output
  for (genvar i = 0; i < OUTPUTS; i++) begin : g_lane
    mmcd_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .index     (LANE_W'(i)),
      .gate_next (lane_gates[i])
    );
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      division_mode <= DIV_INT;
      output_mode   <= OUT_GATE;
      pulse_length  <= PULSE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIVISION: division_mode <= cfg_data[DMODE_W-1:0];
        REG_OUTPUT:   output_mode   <= cfg_data[OMODE_W-1:0];
        REG_PULSE:    pulse_length  <= cfg_data[PULSE_W-1:0];
        default: ;
      endcase
    end
  end

  // tick register
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (sample.ready) begin
      tick_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      tick_clock_edge  <= sample.clock_edge;
      tick_clock_level <= sample.clock_level;
      tick_reset_edge  <= sample.reset_edge;
      tick_random_word <= sample.random_word;
    end
  end

  // started flag and sequence step
  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      step    <= '0;
    end else if (advance) begin
      started <= started_next;
      step    <= step_next;
    end else if (restart_cfg) begin
      step <= '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_gates <= GATE_W'(lane_gates);
    end
  end

`ifndef SYNTHESIS
  // ready drops only when both stages are full and the result is stalled
  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !sample.ready |-> (tick_valid && res_valid && !result.ready))
    else $error("sample ready low without a full stalled pipeline");

  // a reset edge without a clock edge leaves the divider unstarted
  a_reset_edge: assert property (@(posedge clk) disable iff (rst)
    (advance && tick_reset_edge && !tick_clock_edge) |=> !started)
    else $error("started survived a reset edge");

  // a clock edge on a running divider walks the step by one
  a_step_walk: assert property (@(posedge clk) disable iff (rst)
    (advance && tick_clock_edge && !tick_reset_edge && started)
      |=> (step == $past(step) + STEP_W'(1)))
    else $error("sequence step did not advance");

  // a division mode write restarts the sequence
  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    (restart_cfg && !advance) |=> (step == '0))
    else $error("division mode write did not restart the step");

  // an item is moved to the result register only when it can be held
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !result.ready) |=> $stable(res_gates))
    else $error("stalled result overwritten");
`endif

endmodule

>>> rtl/mmcd_lane.sv
// one divider output: phase counter, trigger pulse counter and gate level
// depends on mmcd_pkg (tables, lane_ctrl_t)
module mmcd_lane (
  input  logic                       clk,
  input  logic                       rst,
  input  mmcd_pkg::lane_ctrl_t       ctrl,
  input  logic [mmcd_pkg::LANE_W-1:0] index,
  output logic                       gate_next
);
  import mmcd_pkg::*;

  logic [PHASE_W-1:0] phase;
  logic [PHASE_W-1:0] phase_next;
  logic [PULSE_W-1:0] pulse;
  logic [PULSE_W-1:0] pulse_next;
  logic               gate;

  logic [DIV_W-1:0]   div;
  logic [DIV_W-1:0]   phase_inc;
  logic               on;
  logic [PULSE_W-1:0] pulse_load;
  logic               pulse_high;

  assign div = divisor_of(ctrl.division_mode, index);

  always_comb begin
    phase_next = ctrl.restart ? '0 : phase;
    phase_inc  = {1'b0, phase_next} + DIV_W'(1);
    if (ctrl.phase_advance) begin
      phase_next = (phase_inc >= div) ? '0 : phase_inc[PHASE_W-1:0];
    end
  end

  always_comb begin
    case (ctrl.division_mode)
      DIV_INT, DIV_EVEN, DIV_ODD, DIV_PRIME, DIV_BINARY: begin
        if (ctrl.output_mode == OUT_LONG) begin
          on = (div >> 1) >= {1'b0, phase_next};
        end else begin
          on = phase_next == '0;
        end
      end
      DIV_RANDOM: on = rotl2(ctrl.random_word, index) < RAND_LIMIT[index];
      DIV_SEQ:    on = ctrl.step == index;
      default:    on = 1'b0;
    endcase
  end

  always_comb begin
    pulse_load = pulse;
    if (ctrl.clock_edge && ctrl.output_mode == OUT_TRIG && on && ctrl.pulse_length > pulse) begin
      pulse_load = ctrl.pulse_length;
    end
    pulse_high = pulse_load != '0;
    pulse_next = pulse_high ? pulse_load - PULSE_W'(1) : pulse_load;
  end

  always_comb begin
    gate_next = gate;
    if (ctrl.started) begin
      case (ctrl.output_mode)
        OUT_TRIG: gate_next = pulse_high;
        OUT_ASIS: gate_next = (ctrl.clock_edge ? on : gate) & ctrl.clock_level;
        default: begin
          if (ctrl.clock_edge) begin
            gate_next = on;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      pulse <= '0;
      gate  <= 1'b0;
    end else if (ctrl.update) begin
      phase <= phase_next;
      if (ctrl.started) begin
        pulse <= pulse_next;
      end
      gate <= gate_next;
    end else if (ctrl.restart) begin
      phase <= '0;
    end
  end

endmodule
